/* design/tpps_pkg.sv */
// Shared widths, constants and control types for the timer prescale period solver.
`default_nettype none
package tpps_pkg;

  localparam int CLOCK_W   = 28;
  localparam int RATE_W    = 24;
  localparam int SHIFT_W   = 3;
  localparam int SOURCE_W  = 4;
  localparam int COMPARE_W = 16;
  localparam int PERIOD_W  = 16;
  localparam int ACH_W     = 27;

  localparam logic [CLOCK_W-1:0]  CLOCK_RESET = 28'd24000000;
  localparam logic [SOURCE_W-1:0] SOURCE_BASE = 4'd8;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN  = 16'd2;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic sel_ach;
    logic take_period;
    logic shift_inc;
    logic take_ach;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic div_done;
    logic fits;
    logic last_shift;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* design/tpps_request_if.sv */
// Request channel carrying the requested interrupt rate.
`default_nettype none
interface tpps_request_if;
  import tpps_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_hz;

  modport source (output valid, output rate_hz, input ready);
  modport sink (input valid, input rate_hz, output ready);
endinterface
`default_nettype wire

/* design/tpps_result_if.sv */
// Result channel carrying the chosen prescaler, compare value and achieved rate.
`default_nettype none
interface tpps_result_if;
  import tpps_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SHIFT_W-1:0]   prescale_shift;
  logic [SOURCE_W-1:0]  count_source;
  logic [COMPARE_W-1:0] compare_value;
  logic [ACH_W-1:0]     achieved_rate;
  logic                 rate_error;

  modport source (output valid, output prescale_shift, output count_source,
                  output compare_value, output achieved_rate, output rate_error,
                  input ready);
  modport sink (input valid, input prescale_shift, input count_source,
                input compare_value, input achieved_rate, input rate_error,
                output ready);
endinterface
`default_nettype wire

/* design/tpps_divider.sv */
// Shared restoring divider producing one quotient bit per cycle.
`default_nettype none
module tpps_divider #(
  parameter int NW = 32,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quot,
  output logic          done
);
  localparam int CW = (NW > 2) ? $clog2(NW) : 1;

  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          borrow;
  logic          last;

  assign shifted = {rem, q[NW-1]};
  assign diff    = shifted - {1'b0, d};
  assign borrow  = diff[DW];
  assign last    = (cnt == CW'(NW - 1));
  assign quot    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      d   <= den;
      cnt <= '0;
    end else if (busy) begin
      rem <= borrow ? shifted[DW-1:0] : diff[DW-1:0];
      q   <= {q[NW-2:0], ~borrow};
      cnt <= cnt + CW'(1);
    end
  end
endmodule
`default_nettype wire

/* design/tpps_ctrl.sv */
// Sequencing state machine for the prescale search and rate calculation.
`default_nettype none
module tpps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tpps_pkg::status_t status,
  output tpps_pkg::cmd_t    cmd
);
  import tpps_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_START_P = 3'd2;
  localparam logic [2:0] S_WAIT_P  = 3'd3;
  localparam logic [2:0] S_START_A = 3'd4;
  localparam logic [2:0] S_WAIT_A  = 3'd5;
  localparam logic [2:0] S_FINISH  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = status.rate_zero ? S_FINISH : S_START_P;
      end
      S_START_P: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT_P;
      end
      S_WAIT_P: begin
        if (status.div_done) begin
          if (status.fits || status.last_shift) begin
            cmd.take_period = 1'b1;
            state_next      = S_START_A;
          end else begin
            cmd.shift_inc = 1'b1;
            state_next    = S_START_P;
          end
        end
      end
      S_START_A: begin
        cmd.div_start = 1'b1;
        cmd.sel_ach   = 1'b1;
        state_next    = S_WAIT_A;
      end
      S_WAIT_A: begin
        cmd.sel_ach = 1'b1;
        if (status.div_done) begin
          cmd.take_ach = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

/* design/tpps_datapath.sv */
// Operand registers, divider, period selection and result register.
`default_nettype none
module tpps_datapath #(
  parameter int MAX_SHIFT_STEPS = 8,
  parameter int PERIOD_MAX      = 65535
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tpps_pkg::CLOCK_W-1:0]        cfg_data,
  input  logic [tpps_pkg::RATE_W-1:0]         rate_hz,
  input  tpps_pkg::cmd_t                      cmd,
  output tpps_pkg::status_t                   status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [tpps_pkg::SHIFT_W-1:0]        prescale_shift,
  output logic [tpps_pkg::SOURCE_W-1:0]       count_source,
  output logic [tpps_pkg::COMPARE_W-1:0]      compare_value,
  output logic [tpps_pkg::ACH_W-1:0]          achieved_rate,
  output logic                                rate_error
);
  import tpps_pkg::*;

  localparam int SHW   = (MAX_SHIFT_STEPS > 1) ? $clog2(MAX_SHIFT_STEPS) : 1;
  localparam int EXW   = (SHW > SOURCE_W) ? SHW : SOURCE_W;
  localparam int DW    = RATE_W + MAX_SHIFT_STEPS - 1;
  localparam int NW    = ((DW > CLOCK_W) ? DW : CLOCK_W) + 1;
  localparam logic [SHW-1:0]      LAST_SHIFT = SHW'(MAX_SHIFT_STEPS - 1);
  localparam logic [PERIOD_W-1:0] PMAX       = PERIOD_W'(PERIOD_MAX);

  logic [CLOCK_W-1:0]  clock_freq;
  logic [RATE_W-1:0]   rate;
  logic [SHW-1:0]      shift;
  logic [PERIOD_W-1:0] period;
  logic [ACH_W-1:0]    achieved;
  logic [DW-1:0]       rate_sh;
  logic [DW-1:0]       period_sh;
  logic [NW-1:0]       num_period;
  logic [NW-1:0]       div_num;
  logic [DW-1:0]       div_den;
  logic [NW-1:0]       quot;
  logic                div_done;
  logic [PERIOD_W-1:0] p_low;
  logic [PERIOD_W-1:0] p_clamped;
  logic [EXW-1:0]      shift_ext;

  assign rate_sh    = DW'(rate) << shift;
  assign period_sh  = DW'(period) << shift;
  assign num_period = NW'(clock_freq) + NW'(rate_sh >> 1);
  assign div_num    = cmd.sel_ach ? NW'(clock_freq) : num_period;
  assign div_den    = cmd.sel_ach ? period_sh : rate_sh;

  tpps_divider #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .quot (quot),
    .done (div_done)
  );

  assign p_low     = quot[PERIOD_W-1:0];
  assign p_clamped = (p_low < PERIOD_MIN) ? PERIOD_MIN : p_low;
  assign shift_ext = EXW'(shift);

  assign status.rate_zero  = (rate == '0);
  assign status.div_done   = div_done;
  assign status.fits       = (quot <= NW'(PERIOD_MAX));
  assign status.last_shift = (shift == LAST_SHIFT);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_freq <= CLOCK_RESET;
    end else if (cfg_we) begin
      clock_freq <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rate  <= rate_hz;
      shift <= '0;
    end else if (cmd.shift_inc) begin
      shift <= shift + SHW'(1);
    end
    if (cmd.take_period) begin
      period <= status.fits ? p_clamped : PMAX;
    end
    if (cmd.take_ach) begin
      achieved <= quot[ACH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (status.rate_zero) begin
        prescale_shift <= '0;
        count_source   <= '0;
        compare_value  <= '0;
        achieved_rate  <= '0;
        rate_error     <= 1'b1;
      end else begin
        prescale_shift <= shift_ext[SHIFT_W-1:0];
        count_source   <= SOURCE_BASE + shift_ext[SOURCE_W-1:0];
        compare_value  <= period - PERIOD_W'(1);
        achieved_rate  <= achieved;
        rate_error     <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* design/timer_prescale_period_solver.sv */
// Top level of the timer prescale period solver.
//
// A request carries a wanted interrupt rate in Hz. The block tries prescaler
// shifts from zero upwards, dividing the clock by the shifted rate with
// rounding, and keeps the first shift whose period fits the timer, or else the
// last shift with the period set to its maximum. It then divides the clock by
// the final period and divisor to give the achieved rate. A request of zero Hz
// gives a result with only the error flag set. One request is worked on at a
// time. All divisions share one restoring divider that yields one quotient
// bit per cycle, W bits in all (W is 32 with the default parameters). The user
// must write the clock register through cfg_we and cfg_data only while idle;
// the block itself does not enforce it. The result sits in an output register,
// so the next request is taken while a result waits; a stalled receiver holds
// the block only once a second result is ready. Reset empties the output
// register and sets the clock register to 24 MHz.
`default_nettype none
module timer_prescale_period_solver #(
  parameter int MAX_SHIFT_STEPS = 8,
  parameter int PERIOD_MAX      = 65535
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tpps_pkg::CLOCK_W-1:0] cfg_data,
  tpps_request_if.sink                 request,
  tpps_result_if.source                result
);
  import tpps_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign request.ready = in_ready;

  tpps_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(request.valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  tpps_datapath #(
    .MAX_SHIFT_STEPS(MAX_SHIFT_STEPS),
    .PERIOD_MAX     (PERIOD_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .rate_hz       (request.rate_hz),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .prescale_shift(result.prescale_shift),
    .count_source  (result.count_source),
    .compare_value (result.compare_value),
    .achieved_rate (result.achieved_rate),
    .rate_error    (result.rate_error)
  );
endmodule
`default_nettype wire

/* design/tpps_checker.sv */
// Port-level assertions for the timer prescale period solver and their binding.
`default_nettype none
module tpps_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [tpps_pkg::SHIFT_W-1:0]   prescale_shift,
  input logic [tpps_pkg::SOURCE_W-1:0]  count_source,
  input logic [tpps_pkg::COMPARE_W-1:0] compare_value,
  input logic [tpps_pkg::ACH_W-1:0]     achieved_rate,
  input logic                         rate_error
);
  import tpps_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(compare_value)
      && $stable(achieved_rate) && $stable(prescale_shift) && $stable(rate_error))
    else $error("result changed while stalled");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && rate_error |-> prescale_shift == '0 && count_source == '0
      && compare_value == '0 && achieved_rate == '0)
    else $error("error result carries non-zero fields");

  a_source: assert property (@(posedge clk) disable iff (rst)
    res_valid && !rate_error |-> count_source[SHIFT_W-1:0] == prescale_shift
      && compare_value != '0)
    else $error("count source or compare value inconsistent");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !res_valid |=> !res_valid)
    else $error("result appeared the cycle after a request");
endmodule

bind timer_prescale_period_solver tpps_checker u_tpps_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (request.valid),
  .req_ready     (request.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .prescale_shift(result.prescale_shift),
  .count_source  (result.count_source),
  .compare_value (result.compare_value),
  .achieved_rate (result.achieved_rate),
  .rate_error    (result.rate_error)
);
`default_nettype wire
